@@ src/bpeg_pkg.sv @@
// ============================================================================
// bpeg_pkg: shared definitions for the basin palette entry generator
// Word types, register codes, sequencer states, datapath operations,
// fixed-point constants and the constant lookup tables.
// ============================================================================
package bpeg_pkg;

    // Field and datapath widths.
    localparam int COORD_BITS  = 16;
    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = 8;
    localparam int SIZE_W      = 9;
    localparam int MODE_W      = 2;
    localparam int CHAN_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int DW          = 40;  // x / y working registers (CORDIC and remainders)
    localparam int ZW          = 26;  // angle accumulator / quotient register
    localparam int CNT_W       = 5;
    localparam int SHIFT_W     = 4;
    localparam int PROD_W      = 37;  // 2059125 * f product
    localparam int DIVISOR_W   = 16;  // ramp denominator

    // Palette selection.
    typedef enum logic [MODE_W-1:0] {
        PAL_ANGLE_HUE = 2'd0,
        PAL_BLUE_GOLD = 2'd1,
        PAL_CB_TABLE  = 2'd2,
        PAL_PASTEL    = 2'd3
    } palette_mode_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_SIZE = 2'd1;

    // Input and result words.
    typedef struct packed {
        logic        [IDX_W-1:0]      entry_index;
        logic signed [COORD_BITS-1:0] root_real;
        logic signed [COORD_BITS-1:0] root_imag;
    } in_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } out_word_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_WRAP,
        ST_SECTOR,
        ST_FDIV,
        ST_MUL,
        ST_QSET,
        ST_QDIV,
        ST_TSET,
        ST_TDIV,
        ST_RAMPDIV,
        ST_FINISH
    } seq_state_t;

    // Datapath operations issued by the sequencer.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CORDIC,
        OP_DIV,
        OP_WRAP,
        OP_SECTOR,
        OP_MUL,
        OP_QSET,
        OP_TSET,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [SHIFT_W-1:0] shift;
    } dp_ctl_t;

    // Last iteration index of each loop.
    localparam logic [CNT_W-1:0] CORDIC_LAST = 5'd15;
    localparam logic [CNT_W-1:0] FDIV_LAST   = 5'd15;
    localparam logic [CNT_W-1:0] HDIV_LAST   = 5'd7;
    localparam logic [CNT_W-1:0] RDIV_LAST   = 5'd23;

    // Angles in Q.16 degrees.
    localparam logic signed [ZW-1:0] Z_DEG_90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] Z_DEG_60  = ZW'(60 * 65536);
    localparam logic signed [ZW-1:0] Z_DEG_360 = ZW'(360 * 65536);

    // Divisor of the hue fraction, aligned for a 16-bit quotient.
    localparam logic signed [DW-1:0] F_DIV_TOP   = DW'(60 << 15);
    // Divisor of the q and t channels, aligned for an 8-bit quotient.
    localparam logic signed [DW-1:0] HSV_DIV_TOP = DW'(64'sd655360000 <<< 7);
    // Numerator bases of the q and t channels.
    localparam logic signed [DW-1:0] Q_BASE      = DW'(64'sd2422500 * 64'sd65536);
    localparam logic signed [DW-1:0] T_BASE      = DW'(64'sd363375 * 64'sd65536);
    localparam logic [20:0]          HSV_F_GAIN  = 21'd2059125;

    localparam logic [CHAN_W-1:0] HSV_V = 8'd242;
    localparam logic [CHAN_W-1:0] HSV_P = 8'd36;
    localparam logic [CHAN_W-1:0] ALPHA = 8'd255;

    // Arctangent of 2^-i in Q.16 degrees, rounded to nearest.
    function automatic logic [21:0] atan_deg(input logic [SHIFT_W-1:0] i);
        logic [21:0] a;
        unique case (i)
            4'd0:  a = 22'd2949120;
            4'd1:  a = 22'd1740967;
            4'd2:  a = 22'd919879;
            4'd3:  a = 22'd466945;
            4'd4:  a = 22'd234379;
            4'd5:  a = 22'd117304;
            4'd6:  a = 22'd58666;
            4'd7:  a = 22'd29335;
            4'd8:  a = 22'd14668;
            4'd9:  a = 22'd7334;
            4'd10: a = 22'd3667;
            4'd11: a = 22'd1833;
            4'd12: a = 22'd917;
            4'd13: a = 22'd458;
            4'd14: a = 22'd229;
            4'd15: a = 22'd115;
        endcase
        return a;
    endfunction

    // Eight-entry colorblind-safe table, packed as {red, green, blue}.
    function automatic logic [3*CHAN_W-1:0] cb_color(input logic [2:0] i);
        logic [3*CHAN_W-1:0] c;
        unique case (i)
            3'd0: c = {8'd68,  8'd119, 8'd170};
            3'd1: c = {8'd102, 8'd204, 8'd238};
            3'd2: c = {8'd34,  8'd136, 8'd51};
            3'd3: c = {8'd204, 8'd187, 8'd68};
            3'd4: c = {8'd238, 8'd102, 8'd119};
            3'd5: c = {8'd170, 8'd51,  8'd119};
            3'd6: c = {8'd187, 8'd187, 8'd187};
            3'd7: c = {8'd51,  8'd34,  8'd136};
        endcase
        return c;
    endfunction

endpackage

@@ src/basin_palette_entry_generator.sv @@
// ============================================================================
// basin_palette_entry_generator: palette entry generator, top level
// Holds the configuration registers and joins the sequencer and datapath.
// ============================================================================
// Usage:
//   Input: drive item and raise start; the word is taken at a rising edge
//   where start is high and busy is low. busy stays high while it is worked.
//   Output: one result word per input word. done is high for exactly one
//   cycle with the RGBA word on result; the receiver cannot stall, so the
//   word must be taken in that cycle.
//   Configuration: cfg_valid / cfg_ready write channel; cfg_index 0 is the
//   palette mode, 1 the palette size, other indexes are ignored. cfg_ready
//   is low while busy and while start is high, so a write never lands in
//   the same cycle as an accepted word.
//   Work per word:
//     angle hue   16 CORDIC steps, a 16-step fraction divide and two
//                 8-step channel divides, all through the one shared
//                 add/subtract unit, plus set-up steps
//     ramps       a 24-step position divide
//     table       lookup only
//   A new start is taken in the done cycle; no word is taken while the
//   previous one is still in work.
//   Reset: palette mode 0, palette size 1, block idle, no strobe.
// ============================================================================
module basin_palette_entry_generator #(
    parameter int MAX_ENTRIES = bpeg_pkg::MAX_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bpeg_pkg::in_word_t               item,
    output logic                             done,
    output bpeg_pkg::out_word_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpeg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpeg_pkg::SIZE_W-1:0]      cfg_data
);
    import bpeg_pkg::*;

    palette_mode_t     mode_reg;
    palette_mode_t     mode_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    dp_ctl_t           ctl;

    // Configuration writes are taken only while no word is in work or offered.
    assign cfg_ready = ~busy & ~start;

    always_comb
    begin
        mode_next = mode_reg;
        size_next = size_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PALETTE_MODE: mode_next = palette_mode_t'(cfg_data[MODE_W-1:0]);
                REG_PALETTE_SIZE: size_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= PAL_ANGLE_HUE;
            size_reg <= SIZE_W'(1);
        end
        else
        begin
            mode_reg <= mode_next;
            size_reg <= size_next;
        end
    end

    bpeg_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode_reg),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    bpeg_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .ctl    (ctl),
        .mode   (mode_reg),
        .size   (size_reg),
        .item   (item),
        .result (result)
    );

endmodule

@@ src/bpeg_step_unit.sv @@
// ============================================================================
// bpeg_step_unit: shared add/subtract-shift step
// One CORDIC vectoring iteration or one restoring-division iteration,
// selected by the operation. Both share the same y adder.
// ============================================================================
module bpeg_step_unit (
    input  logic                            is_div,
    input  logic [bpeg_pkg::SHIFT_W-1:0]    shift,
    input  logic signed [bpeg_pkg::DW-1:0]  x,
    input  logic signed [bpeg_pkg::DW-1:0]  y,
    input  logic signed [bpeg_pkg::ZW-1:0]  z,
    output logic signed [bpeg_pkg::DW-1:0]  x_n,
    output logic signed [bpeg_pkg::DW-1:0]  y_n,
    output logic signed [bpeg_pkg::ZW-1:0]  z_n
);
    import bpeg_pkg::*;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] operand;
    logic signed [DW-1:0] sum;
    logic signed [ZW-1:0] atan_z;
    logic                 cin;
    logic                 neg;
    logic                 ge;

    // Shared y adder: y - x when dividing, y -/+ (x >>> i) when rotating.
    always_comb
    begin
        dx     = y >>> shift;
        dy     = x >>> shift;
        neg    = y[DW-1];
        atan_z = ZW'(atan_deg(shift));
        if (is_div)
        begin
            operand = ~x;
            cin     = 1'b1;
        end
        else if (neg)
        begin
            operand = dy;
            cin     = 1'b0;
        end
        else
        begin
            operand = ~dy;
            cin     = 1'b1;
        end
        sum = y + operand + {{(DW-1){1'b0}}, cin};
        ge  = ~sum[DW-1];
    end

    // Next values of the working registers.
    always_comb
    begin
        if (is_div)
        begin
            x_n = x >>> 1;
            y_n = ge ? sum : y;
            z_n = {z[ZW-2:0], ge};
        end
        else
        begin
            x_n = neg ? (x - dx) : (x + dx);
            y_n = sum;
            z_n = neg ? (z - atan_z) : (z + atan_z);
        end
    end

endmodule

@@ src/bpeg_seq.sv @@
// ============================================================================
// bpeg_seq: sequencer of the palette entry generator
// Steps the datapath through the CORDIC, divide and channel phases,
// counts loop iterations and raises the result strobe.
// ============================================================================
module bpeg_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  bpeg_pkg::palette_mode_t     mode,
    output logic                        busy,
    output logic                        done,
    output bpeg_pkg::dp_ctl_t           ctl
);
    import bpeg_pkg::*;

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic             done_reg;
    logic             done_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        PAL_ANGLE_HUE: state_next = ST_CORDIC;
                        PAL_BLUE_GOLD: state_next = ST_RAMPDIV;
                        PAL_CB_TABLE:  state_next = ST_FINISH;
                        PAL_PASTEL:    state_next = ST_RAMPDIV;
                    endcase
                end
            end
            ST_CORDIC:  if (step_reg == CORDIC_LAST) state_next = ST_WRAP;
            ST_WRAP:    state_next = ST_SECTOR;
            ST_SECTOR:  state_next = ST_FDIV;
            ST_FDIV:    if (step_reg == FDIV_LAST) state_next = ST_MUL;
            ST_MUL:     state_next = ST_QSET;
            ST_QSET:    state_next = ST_QDIV;
            ST_QDIV:    if (step_reg == HDIV_LAST) state_next = ST_TSET;
            ST_TSET:    state_next = ST_TDIV;
            ST_TDIV:    if (step_reg == HDIV_LAST) state_next = ST_FINISH;
            ST_RAMPDIV: if (step_reg == RDIV_LAST) state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Iteration counter restarts on every phase change.
    always_comb
    begin
        if (state_next != state_reg || state_reg == ST_IDLE)
            step_next = '0;
        else
            step_next = step_reg + 1'b1;
        done_next = (state_reg == ST_FINISH);
    end

    // Datapath operation for the current state.
    always_comb
    begin
        ctl.shift = step_reg[SHIFT_W-1:0];
        unique case (state_reg)
            ST_IDLE:    ctl.op = start ? OP_LOAD : OP_NONE;
            ST_CORDIC:  ctl.op = OP_CORDIC;
            ST_WRAP:    ctl.op = OP_WRAP;
            ST_SECTOR:  ctl.op = OP_SECTOR;
            ST_FDIV:    ctl.op = OP_DIV;
            ST_MUL:     ctl.op = OP_MUL;
            ST_QSET:    ctl.op = OP_QSET;
            ST_QDIV:    ctl.op = OP_DIV;
            ST_TSET:    ctl.op = OP_TSET;
            ST_TDIV:    ctl.op = OP_DIV;
            ST_RAMPDIV: ctl.op = OP_DIV;
            ST_FINISH:  ctl.op = OP_FINISH;
            default:    ctl.op = OP_NONE;
        endcase
        busy = (state_reg != ST_IDLE);
        done = done_reg;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // An accepted item always starts work.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // The result strobe comes only in the cycle after the finishing step.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without a finishing step");

    // The block is free again while the result is shown.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    // The channel divides never run past their eight quotient bits.
    a_hdiv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QDIV || state_reg == ST_TDIV) |-> step_reg <= HDIV_LAST)
        else $error("channel divide ran too long");

endmodule

@@ src/bpeg_datapath.sv @@
// ============================================================================
// bpeg_datapath: working registers and channel formation
// Holds the CORDIC / divide registers around the shared step unit, folds
// the angle into a hue, and forms the RGBA word for every palette type.
// ============================================================================
module bpeg_datapath #(
    parameter int MAX_ENTRIES = bpeg_pkg::MAX_ENTRIES
) (
    input  logic                        clk,
    input  bpeg_pkg::dp_ctl_t           ctl,
    input  bpeg_pkg::palette_mode_t     mode,
    input  logic [bpeg_pkg::SIZE_W-1:0] size,
    input  bpeg_pkg::in_word_t          item,
    output bpeg_pkg::out_word_t         result
);
    import bpeg_pkg::*;

    localparam int RW = 36;  // ramp channel arithmetic

    localparam logic signed [ZW-1:0] Z_SEC1 = Z_DEG_60;
    localparam logic signed [ZW-1:0] Z_SEC2 = ZW'(2 * 60 * 65536);
    localparam logic signed [ZW-1:0] Z_SEC3 = ZW'(3 * 60 * 65536);
    localparam logic signed [ZW-1:0] Z_SEC4 = ZW'(4 * 60 * 65536);
    localparam logic signed [ZW-1:0] Z_SEC5 = ZW'(5 * 60 * 65536);

    localparam logic signed [RW-1:0] BG_R0 = RW'(30 * 65536);
    localparam logic signed [RW-1:0] BG_G0 = RW'(80 * 65536);
    localparam logic signed [RW-1:0] BG_B0 = RW'(200 * 65536);
    localparam logic signed [RW-1:0] PA_R0 = RW'(200 * 65536);
    localparam logic signed [RW-1:0] PA_G0 = RW'(180 * 65536);
    localparam logic signed [RW-1:0] PA_B0 = RW'(220 * 65536);
    localparam logic signed [RW-1:0] K200  = RW'(200);
    localparam logic signed [RW-1:0] K140  = RW'(140);
    localparam logic signed [RW-1:0] K120  = RW'(120);
    localparam logic signed [RW-1:0] K40   = RW'(40);
    localparam logic signed [RW-1:0] K30   = RW'(30);
    localparam logic signed [RW-1:0] K60   = RW'(60);
    localparam logic signed [RW-1:0] HALF  = RW'(32768);

    logic signed [DW-1:0]   x_reg;
    logic signed [DW-1:0]   y_reg;
    logic signed [ZW-1:0]   z_reg;
    logic signed [DW-1:0]   x_n;
    logic signed [DW-1:0]   y_n;
    logic signed [ZW-1:0]   z_n;
    logic [2:0]             sector_reg;
    logic [PROD_W-1:0]      p_reg;
    logic [CHAN_W-1:0]      q_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   zero_reg;
    out_word_t              result_reg;

    logic signed [DW-1:0]   xs;
    logic signed [DW-1:0]   ys;
    logic [DIVISOR_W:0]     size_sat;
    logic [DIVISOR_W-1:0]   divisor;
    logic signed [ZW-1:0]   z_wrap1;
    logic signed [ZW-1:0]   z_wrap2;
    logic signed [ZW-1:0]   hue;
    logic [2:0]             sector;
    logic signed [ZW-1:0]   sector_base;
    logic signed [RW-1:0]   ramp_t;
    logic [3*CHAN_W-1:0]    rgb;

    // Round or truncate a Q.16 ramp value, then clamp to one channel.
    function automatic logic [CHAN_W-1:0] ramp_chan(input logic signed [RW-1:0] v,
                                                     input logic rnd);
        logic signed [RW-1:0] w;
        logic [RW-17:0]       s;
        logic [CHAN_W-1:0]    c;
        w = v + (rnd ? HALF : RW'(0));
        s = w[RW-1:16];
        if (v[RW-1])
            c = '0;
        else if (s > (RW-16)'(255))
            c = 8'd255;
        else
            c = s[CHAN_W-1:0];
        return c;
    endfunction

    bpeg_step_unit u_step (
        .is_div (ctl.op == OP_DIV),
        .shift  (ctl.shift),
        .x      (x_reg),
        .y      (y_reg),
        .z      (z_reg),
        .x_n    (x_n),
        .y_n    (y_n),
        .z_n    (z_n)
    );

    // Scaled coordinates and the ramp denominator for loading.
    always_comb
    begin
        xs = DW'(item.root_real) <<< 14;
        ys = DW'(item.root_imag) <<< 14;
        if ((DIVISOR_W + 1)'(size) > (DIVISOR_W + 1)'(MAX_ENTRIES))
            size_sat = (DIVISOR_W + 1)'(MAX_ENTRIES);
        else
            size_sat = (DIVISOR_W + 1)'(size);
        if (size_sat >= (DIVISOR_W + 1)'(2))
            divisor = DIVISOR_W'(size_sat - 1'b1);
        else
            divisor = DIVISOR_W'(1);
    end

    // Fold the CORDIC angle into 0..360 degrees; the origin maps to hue zero.
    always_comb
    begin
        z_wrap1 = z_reg[ZW-1] ? (z_reg + Z_DEG_360) : z_reg;
        z_wrap2 = (z_wrap1 >= Z_DEG_360) ? (z_wrap1 - Z_DEG_360) : z_wrap1;
        if (zero_reg || z_wrap2[ZW-1])
            hue = '0;
        else
            hue = z_wrap2;
    end

    // Sixty-degree sector of the hue held in z.
    always_comb
    begin
        priority if (z_reg >= Z_SEC5)
        begin
            sector      = 3'd5;
            sector_base = Z_SEC5;
        end
        else if (z_reg >= Z_SEC4)
        begin
            sector      = 3'd4;
            sector_base = Z_SEC4;
        end
        else if (z_reg >= Z_SEC3)
        begin
            sector      = 3'd3;
            sector_base = Z_SEC3;
        end
        else if (z_reg >= Z_SEC2)
        begin
            sector      = 3'd2;
            sector_base = Z_SEC2;
        end
        else if (z_reg >= Z_SEC1)
        begin
            sector      = 3'd1;
            sector_base = Z_SEC1;
        end
        else
        begin
            sector      = 3'd0;
            sector_base = '0;
        end
    end

    // Channel formation for the finished item.
    always_comb
    begin
        ramp_t = RW'(z_reg[23:0]);
        unique case (mode)
            PAL_ANGLE_HUE:
            begin
                unique case (sector_reg)
                    3'd0:    rgb = {HSV_V, z_reg[CHAN_W-1:0], HSV_P};
                    3'd1:    rgb = {q_reg, HSV_V, HSV_P};
                    3'd2:    rgb = {HSV_P, HSV_V, z_reg[CHAN_W-1:0]};
                    3'd3:    rgb = {HSV_P, q_reg, HSV_V};
                    3'd4:    rgb = {z_reg[CHAN_W-1:0], HSV_P, HSV_V};
                    default: rgb = {HSV_V, HSV_P, q_reg};
                endcase
            end
            PAL_BLUE_GOLD:
                rgb = {ramp_chan(BG_R0 + K200 * ramp_t, 1'b1),
                       ramp_chan(BG_G0 + K140 * ramp_t, 1'b1),
                       ramp_chan(BG_B0 - K120 * ramp_t, 1'b1)};
            PAL_CB_TABLE:
                rgb = cb_color(idx_reg[2:0]);
            PAL_PASTEL:
                rgb = {ramp_chan(PA_R0 - K40 * ramp_t, 1'b0),
                       ramp_chan(PA_G0 + K30 * ramp_t, 1'b0),
                       ramp_chan(PA_B0 - K60 * ramp_t, 1'b0)};
        endcase
    end

    // Working registers, one operation per cycle.
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                idx_reg  <= item.entry_index;
                zero_reg <= (item.root_real == '0) && (item.root_imag == '0);
                if (mode == PAL_ANGLE_HUE)
                begin
                    // Pre-rotate the left half plane by ninety degrees.
                    if (item.root_real[COORD_BITS-1])
                    begin
                        if (!item.root_imag[COORD_BITS-1])
                        begin
                            x_reg <= ys;
                            y_reg <= -xs;
                            z_reg <= Z_DEG_90;
                        end
                        else
                        begin
                            x_reg <= -ys;
                            y_reg <= xs;
                            z_reg <= -Z_DEG_90;
                        end
                    end
                    else
                    begin
                        x_reg <= xs;
                        y_reg <= ys;
                        z_reg <= '0;
                    end
                end
                else
                begin
                    // Ramp position: (index << 16) / denominator, 24 quotient bits.
                    y_reg <= DW'({item.entry_index, 16'h0000});
                    x_reg <= DW'(divisor) <<< 23;
                    z_reg <= '0;
                end
            end
            OP_CORDIC, OP_DIV:
            begin
                x_reg <= x_n;
                y_reg <= y_n;
                z_reg <= z_n;
            end
            OP_WRAP:
                z_reg <= hue;
            OP_SECTOR:
            begin
                sector_reg <= sector;
                y_reg      <= DW'(z_reg - sector_base);
                x_reg      <= F_DIV_TOP;
                z_reg      <= '0;
            end
            OP_MUL:
                p_reg <= PROD_W'(HSV_F_GAIN) * PROD_W'(z_reg[15:0]);
            OP_QSET:
            begin
                y_reg <= Q_BASE - DW'(p_reg);
                x_reg <= HSV_DIV_TOP;
                z_reg <= '0;
            end
            OP_TSET:
            begin
                q_reg <= z_reg[CHAN_W-1:0];
                y_reg <= T_BASE + DW'(p_reg);
                x_reg <= HSV_DIV_TOP;
                z_reg <= '0;
            end
            OP_FINISH:
            begin
                result_reg.red   <= rgb[3*CHAN_W-1:2*CHAN_W];
                result_reg.green <= rgb[2*CHAN_W-1:CHAN_W];
                result_reg.blue  <= rgb[CHAN_W-1:0];
                result_reg.alpha <= ALPHA;
            end
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the basin palette entry generator
// A driver presents input words and register writes from a queue filled at
// time zero. A monitor predicts each palette entry when its word is taken and
// compares it field by field with the result word that the block strobes out.
// ============================================================================
module tb_top;
    import bpeg_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 64;

    // Register indexes that the block ignores.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // Fixed-point constants of the angle hue path.
    localparam longint SECTOR_Q16    = 64'sd60 * 64'sd65536;
    localparam longint FULL_TURN_Q16 = 64'sd360 * 64'sd65536;
    localparam longint RIGHT_Q16     = 64'sd90 * 64'sd65536;
    localparam longint Q_NUMER       = 64'sd2422500 * 64'sd65536;
    localparam longint T_NUMER       = 64'sd363375 * 64'sd65536;
    localparam longint F_GAIN        = 64'sd2059125;
    localparam longint HSV_DENOM     = 64'sd655360000;

    typedef enum logic [1:0] {ACT_WORD, ACT_WRITE, ACT_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t                kind;
        in_word_t                  word;
        logic [CFG_INDEX_W-1:0]    reg_index;
        logic [SIZE_W-1:0]         reg_data;
        bit                        gaps;
    } stim_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    in_word_t               item      = '0;
    logic                   done;
    out_word_t              result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]      cfg_data  = '0;

    stim_t         pending_words[$];
    out_word_t     expected_entries[$];
    palette_mode_t mode_cfg = PAL_ANGLE_HUE;
    logic [SIZE_W-1:0] size_cfg = 9'd1;

    int words_sent      = 0;
    int words_taken     = 0;
    int writes_sent     = 0;
    int writes_taken    = 0;
    int entries_checked = 0;
    int total_words     = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int quiet_cycles    = 0;

    basin_palette_entry_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Arctangent of 2^-i in Q.16 degrees.
    function automatic longint atan_step(int i);
        case (i)
            0:       return 2949120;
            1:       return 1740967;
            2:       return 919879;
            3:       return 466945;
            4:       return 234379;
            5:       return 117304;
            6:       return 58666;
            7:       return 29335;
            8:       return 14668;
            9:       return 7334;
            10:      return 3667;
            11:      return 1833;
            12:      return 917;
            13:      return 458;
            14:      return 229;
            default: return 115;
        endcase
    endfunction

    // Colorblind-safe table, {red, green, blue}.
    function automatic logic [23:0] safe_color(logic [2:0] i);
        case (i)
            3'd0:    return 24'h4477AA;
            3'd1:    return 24'h66CCEE;
            3'd2:    return 24'h228833;
            3'd3:    return 24'hCCBB44;
            3'd4:    return 24'hEE6677;
            3'd5:    return 24'hAA3377;
            3'd6:    return 24'hBBBBBB;
            default: return 24'h332288;
        endcase
    endfunction

    // Argument of the root as a hue in Q.16 degrees, by vectoring CORDIC.
    function automatic longint root_hue(logic signed [COORD_BITS-1:0] re,
                                        logic signed [COORD_BITS-1:0] im);
        longint x;
        longint y;
        longint z;
        longint tx;
        longint dx;
        longint dy;
        x = longint'(re) * 16384;
        y = longint'(im) * 16384;
        z = 0;
        if (re == 0 && im == 0)
            return 0;
        // Rotate the left half plane by a quarter turn first.
        if (x < 0)
        begin
            tx = x;
            if (y >= 0)
            begin
                x = y;
                y = -tx;
                z = RIGHT_Q16;
            end
            else
            begin
                x = -y;
                y = tx;
                z = -RIGHT_Q16;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        if (z < 0)
            z = z + FULL_TURN_Q16;
        if (z >= FULL_TURN_Q16)
            z = z - FULL_TURN_Q16;
        if (z < 0)
            z = 0;
        return z;
    endfunction

    // Six-sector HSV to RGB with saturation 0.85 and value 0.95, floored.
    function automatic out_word_t hue_entry(longint hue);
        longint    sector;
        longint    frac;
        longint    q;
        longint    t;
        out_word_t o;
        sector = hue / SECTOR_Q16;
        frac   = (hue - sector * SECTOR_Q16) / 60;
        q      = (Q_NUMER - F_GAIN * frac) / HSV_DENOM;
        t      = (T_NUMER + F_GAIN * frac) / HSV_DENOM;
        o.alpha = 8'd255;
        case (sector)
            0:       {o.red, o.green, o.blue} = {8'd242, 8'(t), 8'd36};
            1:       {o.red, o.green, o.blue} = {8'(q), 8'd242, 8'd36};
            2:       {o.red, o.green, o.blue} = {8'd36, 8'd242, 8'(t)};
            3:       {o.red, o.green, o.blue} = {8'd36, 8'(q), 8'd242};
            4:       {o.red, o.green, o.blue} = {8'(t), 8'd36, 8'd242};
            default: {o.red, o.green, o.blue} = {8'd242, 8'd36, 8'(q)};
        endcase
        return o;
    endfunction

    // One ramp channel from a Q.16 level: rounded or truncated, then clamped.
    function automatic logic [7:0] ramp_level(longint acc, bit round_half);
        longint v;
        if (acc < 0)
            v = -1;
        else if (round_half)
            v = (acc + 32768) / 65536;
        else
            v = acc / 65536;
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // Palette entry for one input word under the current register copy.
    function automatic out_word_t predict_entry(in_word_t w);
        longint    sz;
        longint    d;
        longint    t;
        out_word_t o;
        sz = (size_cfg > MAX_ENTRIES) ? MAX_ENTRIES : size_cfg;
        d  = (sz >= 2) ? sz - 1 : 1;
        t  = (longint'(w.entry_index) * 65536) / d;
        o.alpha = 8'd255;
        case (mode_cfg)
            PAL_ANGLE_HUE:
                o = hue_entry(root_hue(w.root_real, w.root_imag));
            PAL_BLUE_GOLD:
            begin
                o.red   = ramp_level(longint'(30) * 65536 + 200 * t, 1'b1);
                o.green = ramp_level(longint'(80) * 65536 + 140 * t, 1'b1);
                o.blue  = ramp_level(longint'(200) * 65536 - 120 * t, 1'b1);
            end
            PAL_CB_TABLE:
                {o.red, o.green, o.blue} = safe_color(w.entry_index[2:0]);
            default:
            begin
                o.red   = ramp_level(longint'(200) * 65536 - 40 * t, 1'b0);
                o.green = ramp_level(longint'(180) * 65536 + 30 * t, 1'b0);
                o.blue  = ramp_level(longint'(220) * 65536 - 60 * t, 1'b0);
            end
        endcase
        return o;
    endfunction

    task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic push_word(logic [IDX_W-1:0] idx, logic [15:0] re, logic [15:0] im,
                             bit gaps);
        stim_t s;
        s.kind             = ACT_WORD;
        s.word.entry_index = idx;
        s.word.root_real   = re;
        s.word.root_imag   = im;
        s.reg_index        = '0;
        s.reg_data         = '0;
        s.gaps             = gaps;
        pending_words.insert(pending_words.size(), s);
        total_words++;
    endtask

    task automatic push_write(logic [CFG_INDEX_W-1:0] idx, logic [SIZE_W-1:0] data);
        stim_t s;
        s.kind      = ACT_WRITE;
        s.word      = '0;
        s.reg_index = idx;
        s.reg_data  = data;
        s.gaps      = 1'b1;
        pending_words.insert(pending_words.size(), s);
    endtask

    task automatic push_drain();
        stim_t s;
        s.kind      = ACT_DRAIN;
        s.word      = '0;
        s.reg_index = '0;
        s.reg_data  = '0;
        s.gaps      = 1'b1;
        pending_words.insert(pending_words.size(), s);
    endtask

    // Root coordinate with weight on the extremes, the axes and small values.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: presents words and register writes at the falling edge.
    always @(negedge clk)
    begin : drive
        stim_t    nxt;
        logic     start_n;
        logic     write_n;
        in_word_t word_n;
        start_n = start;
        write_n = cfg_valid;
        word_n  = item;
        // Retire whatever the block took at the last rising edge.
        if (start && words_taken == words_sent)
            start_n = 1'b0;
        if (cfg_valid && writes_taken == writes_sent)
            write_n = 1'b0;
        // Count cycles with the block idle and nothing outstanding.
        if (expected_entries.size() == 0 && !busy && !start_n)
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (rst_n && !start_n && !write_n && pending_words.size() != 0)
        begin
            nxt = pending_words[0];
            case (nxt.kind)
                ACT_WORD:
                    if (!nxt.gaps || $urandom_range(99) >= 30)
                    begin
                        void'(pending_words.pop_front());
                        start_n = 1'b1;
                        word_n  = nxt.word;
                        words_sent++;
                    end
                ACT_WRITE:
                    if (quiet_cycles >= SETTLE_CYCLES && $urandom_range(99) >= 30)
                    begin
                        void'(pending_words.pop_front());
                        write_n = 1'b1;
                        cfg_index <= nxt.reg_index;
                        cfg_data  <= nxt.reg_data;
                        writes_sent++;
                    end
                default:
                    if (quiet_cycles >= SETTLE_CYCLES)
                        void'(pending_words.pop_front());
            endcase
        end
        // Junk on the input port while no word is offered.
        if (!start_n)
        begin
            word_n.entry_index = 8'($urandom);
            word_n.root_real   = 16'($urandom);
            word_n.root_imag   = 16'($urandom);
        end
        start     <= start_n;
        cfg_valid <= write_n;
        item      <= word_n;
    end

    // Monitor: predicts on each taken word, checks each strobed result.
    always @(posedge clk)
    begin : monitor
        out_word_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d entries outstanding", $time,
                     expected_entries.size());
            $display("Some tests failed");
            $finish;
        end
        else if (!rst_n)
        begin
            mode_cfg = PAL_ANGLE_HUE;
            size_cfg = 9'd1;
        end
        else
        begin
            if (done)
            begin
                if (expected_entries.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none actual %h", $time, result);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_entries.pop_front();
                    check_chan("red", want.red, result.red);
                    check_chan("green", want.green, result.green);
                    check_chan("blue", want.blue, result.blue);
                    check_chan("alpha", want.alpha, result.alpha);
                    entries_checked++;
                end
            end
            if (start && !busy)
            begin
                expected_entries.insert(expected_entries.size(), predict_entry(item));
                words_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PALETTE_MODE: mode_cfg = palette_mode_t'(cfg_data[MODE_W-1:0]);
                    REG_PALETTE_SIZE: size_cfg = cfg_data;
                    default:          ;
                endcase
                writes_taken++;
            end
        end
    end

    initial
    begin : stimulus
        int                mode_pick;
        int                size_pick;
        int                eff_size;
        int                n_words;
        int                drain_at;
        logic [SIZE_W-1:0] reg_word;
        logic [IDX_W-1:0]  idx;

        // Directed: reset settings give angle hue; corners, axes, origin.
        push_word(8'($urandom), 16'h0000, 16'h0000, 1'b1);
        push_word(8'($urandom), 16'h7FFF, 16'h0000, 1'b1);
        push_word(8'($urandom), 16'h8000, 16'h0000, 1'b1);
        push_word(8'($urandom), 16'h0000, 16'h7FFF, 1'b1);
        push_word(8'($urandom), 16'h0000, 16'h8000, 1'b1);
        push_word(8'($urandom), 16'h8000, 16'h8000, 1'b1);
        push_word(8'($urandom), 16'h7FFF, 16'h8000, 1'b1);
        push_word(8'($urandom), 16'hFFFF, 16'h0001, 1'b1);
        push_word(8'($urandom), 16'h8000, 16'h0001, 1'b1);
        push_word(8'($urandom), 16'h0001, 16'h0000, 1'b1);
        // Blue-gold with a size below two: denominator one, clamped channels.
        push_write(REG_PALETTE_MODE, 9'(PAL_BLUE_GOLD));
        push_write(REG_PALETTE_SIZE, 9'd0);
        push_word(8'd0, 16'($urandom), 16'($urandom), 1'b1);
        push_word(8'd255, 16'($urandom), 16'($urandom), 1'b1);
        push_write(REG_PALETTE_SIZE, 9'd256);
        push_word(8'd0, 16'($urandom), 16'($urandom), 1'b1);
        push_word(8'd128, 16'($urandom), 16'($urandom), 1'b1);
        push_word(8'd255, 16'($urandom), 16'($urandom), 1'b1);
        // Pastel at full size, a saturated size, and past the last entry.
        push_write(REG_PALETTE_MODE, 9'(PAL_PASTEL));
        push_word(8'd0, 16'($urandom), 16'($urandom), 1'b1);
        push_word(8'd255, 16'($urandom), 16'($urandom), 1'b1);
        push_write(REG_PALETTE_SIZE, 9'd511);
        push_word(8'd255, 16'($urandom), 16'($urandom), 1'b1);
        push_write(REG_PALETTE_SIZE, 9'd2);
        push_word(8'd1, 16'($urandom), 16'($urandom), 1'b1);
        push_word(8'd200, 16'($urandom), 16'($urandom), 1'b1);
        // Table wraps the index; a write to an unused index changes nothing.
        push_write(REG_PALETTE_MODE, 9'(PAL_CB_TABLE));
        push_write(REG_SPARE_A, 9'h1FF);
        push_word(8'd7, 16'($urandom), 16'($urandom), 1'b1);
        push_word(8'd8, 16'($urandom), 16'($urandom), 1'b1);
        push_word(8'd255, 16'($urandom), 16'($urandom), 1'b1);

        // Random phases, each under one register setting.
        eff_size = 2;
        for (int ph = 0; ph < 22; ph++)
        begin
            if (ph < 4)
                mode_pick = ph;
            else if ($urandom_range(9) < 4)
                mode_pick = PAL_ANGLE_HUE;
            else
                mode_pick = $urandom_range(3);
            case ($urandom_range(9))
                0:       size_pick = 0;
                1:       size_pick = 1;
                2:       size_pick = 2;
                3:       size_pick = 256;
                4:       size_pick = 257;
                5:       size_pick = 511;
                6:       size_pick = 255;
                default: size_pick = $urandom_range(511);
            endcase
            reg_word      = 9'($urandom);
            reg_word[1:0] = 2'(mode_pick);
            if ($urandom_range(1))
            begin
                push_write(REG_PALETTE_SIZE, 9'(size_pick));
                push_write(REG_PALETTE_MODE, reg_word);
            end
            else
            begin
                push_write(REG_PALETTE_MODE, reg_word);
                push_write(REG_PALETTE_SIZE, 9'(size_pick));
            end
            if ($urandom_range(5) == 0)
                push_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 9'($urandom));
            eff_size = (size_pick > 256) ? 256 : ((size_pick < 1) ? 1 : size_pick);
            // One long phase offers its words with no random gaps.
            n_words  = (ph == 10) ? 45 : 18 + $urandom_range(10);
            drain_at = $urandom_range(2 * n_words);
            for (int k = 0; k < n_words; k++)
            begin
                if (k == drain_at)
                    push_drain();
                if ($urandom_range(1))
                    idx = 8'($urandom_range(eff_size - 1));
                else
                    idx = 8'($urandom);
                push_word(idx, pick_coord(), pick_coord(), ph != 10);
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (entries_checked < total_words)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_entries.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/bpeg_pkg.sv
src/bpeg_step_unit.sv
src/bpeg_seq.sv
src/bpeg_datapath.sv
src/basin_palette_entry_generator.sv
tb/tb_top.sv
